### rtl/cfn_pkg.sv
package cfn_pkg;

  localparam int NODE_COUNT_DEFAULT = 1024;
  localparam int QUEUE_DEPTH = 2;

  localparam int NODE_W = 10;
  localparam int BYTE_W = 8;
  localparam int CALM_W = 5;
  localparam int CFG_INDEX_W = 8;

  localparam logic [BYTE_W-1:0] FLAME_MAX = 8'd255;

  // Command codes.
  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_WIND_VARIABILITY = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FLAME_AGILITY = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WIND_CALMNESS = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WIND_BASELINE = 8'd3;

  localparam logic [BYTE_W-1:0] WIND_VARIABILITY_RESET = 8'd5;
  localparam logic [BYTE_W-1:0] FLAME_AGILITY_RESET = 8'd2;
  localparam logic [CALM_W-1:0] WIND_CALMNESS_RESET = 5'd2;
  localparam logic [BYTE_W-1:0] WIND_BASELINE_RESET = 8'd30;

  typedef struct packed {
    logic              cmd;
    logic [NODE_W-1:0] node;
    logic [BYTE_W-1:0] red_gust_draw;
    logic [BYTE_W-1:0] red_gust_value;
    logic [BYTE_W-1:0] red_knock_draw;
    logic [BYTE_W-1:0] red_knock_value;
    logic [BYTE_W-1:0] green_gust_draw;
    logic [BYTE_W-1:0] green_gust_value;
    logic [BYTE_W-1:0] green_knock_draw;
    logic [BYTE_W-1:0] green_knock_value;
  } cfn_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_out;
    logic [BYTE_W-1:0] red_out;
    logic [6:0]        green_out;
  } cfn_result_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [BYTE_W-1:0]      value;
  } cfn_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] wind_variability;
    logic [BYTE_W-1:0] flame_agility;
    logic [CALM_W-1:0] wind_calmness;
    logic [BYTE_W-1:0] wind_baseline;
  } cfn_regs_t;

  // A classified item as it sits in the queue between front and back.
  typedef struct packed {
    logic      in_range;
    cfn_item_t item;
  } cfn_op_t;

  typedef struct packed {
    logic    valid;
    cfn_op_t op;
  } cfn_head_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red_flame;
    logic [BYTE_W-1:0] red_glow;
    logic [BYTE_W-1:0] green_flame;
    logic [BYTE_W-1:0] green_glow;
    logic [BYTE_W-1:0] wind_level;
  } cfn_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] wind;
    logic [BYTE_W-1:0] flame;
    logic [BYTE_W-1:0] glow;
  } cfn_chan_t;

  // One color channel: gust, decay, rise, knockdown, then glow slew.
  function automatic cfn_chan_t channel_step(input cfn_chan_t s,
                                             input logic [BYTE_W-1:0] gust_draw,
                                             input logic [BYTE_W-1:0] gust_value,
                                             input logic [BYTE_W-1:0] knock_draw,
                                             input logic [BYTE_W-1:0] knock_value,
                                             input cfn_regs_t regs);
    logic [BYTE_W-1:0] w;
    logic [BYTE_W-1:0] f;
    logic [BYTE_W-1:0] g;
    logic [BYTE_W-1:0] odds;
    logic [BYTE_W:0]   up;
    cfn_chan_t         r;
    w = (gust_draw < regs.wind_variability) ? gust_value : s.wind;
    if (w > regs.wind_baseline) w = w - 8'd1;
    f = s.flame;
    if (f < FLAME_MAX) f = f + 8'd1;
    odds = w >> regs.wind_calmness;
    if (knock_draw < odds) f = knock_value;
    g = s.glow;
    up = {1'b0, g} + {1'b0, regs.flame_agility};
    if (f > g) begin
      if (up < {1'b0, FLAME_MAX}) g = up[BYTE_W-1:0];
    end else if (g > regs.flame_agility) begin
      g = g - regs.flame_agility;
    end
    r.wind = w;
    r.flame = f;
    r.glow = g;
    return r;
  endfunction

endpackage

### rtl/cfn_stream_if.sv
interface cfn_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/cfn_ram.sv
module cfn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read at the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

### rtl/cfn_front.sv
module cfn_front #(
  parameter int NODE_COUNT = cfn_pkg::NODE_COUNT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  cfn_stream_if.sink        item,
  input  logic              pop,
  output cfn_pkg::cfn_head_t head
);
  import cfn_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cfn_op_t          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             take;
  logic [31:0]      node_wide;
  cfn_op_t          op_in;

  assign node_wide = 32'(item.data.node);
  assign op_in.in_range = node_wide < 32'(NODE_COUNT);
  assign op_in.item = item.data;

  assign item.ready = count < CNT_W'(QUEUE_DEPTH);
  assign push = item.valid && item.ready;
  assign take = pop && (count != '0);

  assign head.valid = count != '0;
  assign head.op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= op_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

endmodule

### rtl/cfn_back.sv
module cfn_back #(
  parameter int NODE_COUNT = cfn_pkg::NODE_COUNT_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  cfn_pkg::cfn_head_t head,
  output logic               pop,
  input  cfn_pkg::cfn_regs_t regs,
  cfn_stream_if.source       result
);
  import cfn_pkg::*;

  localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  logic        b_valid;
  cfn_op_t     b_op;
  logic        b_adv;
  logic        o_valid;
  cfn_result_t o_data;

  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] b_addr;
  cfn_state_t        rd_data;
  logic              wr_en;
  cfn_state_t        wr_data;

  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;
  cfn_state_t        fwd_data;

  cfn_state_t  cur;
  cfn_chan_t   red_next;
  cfn_chan_t   green_in;
  cfn_chan_t   green_next;
  cfn_state_t  upd;
  cfn_result_t res;
  logic [31:0] head_node_wide;
  logic [31:0] b_node_wide;

  assign b_adv = b_valid && (!o_valid || result.ready);
  assign pop = head.valid && (!b_valid || b_adv);

  assign head_node_wide = 32'(head.op.item.node);
  assign b_node_wide = 32'(b_op.item.node);
  assign rd_addr = head_node_wide[ADDR_W-1:0];
  assign b_addr = b_node_wide[ADDR_W-1:0];

  cfn_ram #(
    .WIDTH ($bits(cfn_state_t)),
    .DEPTH (NODE_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (b_addr),
    .wdata (wr_data),
    .re    (pop),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // The item now in the back stage read the memory at the same edge that the
  // item before it wrote; that write is taken from the forward register.
  assign cur = (fwd_valid && (fwd_addr == b_addr)) ? fwd_data : rd_data;

  always_comb begin
    red_next = channel_step('{wind: cur.wind_level, flame: cur.red_flame,
                              glow: cur.red_glow},
                            b_op.item.red_gust_draw, b_op.item.red_gust_value,
                            b_op.item.red_knock_draw, b_op.item.red_knock_value, regs);
    green_in.wind = red_next.wind;
    green_in.flame = cur.green_flame;
    green_in.glow = cur.green_glow;
    green_next = channel_step(green_in,
                              b_op.item.green_gust_draw, b_op.item.green_gust_value,
                              b_op.item.green_knock_draw, b_op.item.green_knock_value,
                              regs);
    upd.red_flame = red_next.flame;
    upd.red_glow = red_next.glow;
    upd.green_flame = green_next.flame;
    upd.wind_level = green_next.wind;
    upd.green_glow = green_next.glow;
    // Green glow never outshines red glow; it is also clamped to red glow when green flame exceeds red flame.
    if ((green_next.glow > red_next.glow) || (green_next.flame > red_next.flame)) begin
      upd.green_glow = red_next.glow;
    end

    if (b_op.item.cmd == CMD_LOAD) begin
      wr_data.red_flame = b_op.item.red_gust_draw;
      wr_data.red_glow = b_op.item.red_gust_value;
      wr_data.green_flame = b_op.item.red_knock_draw;
      wr_data.green_glow = b_op.item.red_knock_value;
      wr_data.wind_level = b_op.item.green_gust_draw;
    end else begin
      wr_data = upd;
    end

    res.node_out = b_op.item.node;
    if (b_op.in_range) begin
      res.red_out = wr_data.red_glow;
      res.green_out = wr_data.green_glow[BYTE_W-1:1];
    end else begin
      res.red_out = '0;
      res.green_out = '0;
    end
  end

  assign wr_en = b_adv && b_op.in_range;

  always_ff @(posedge clk) begin
    if (pop) b_op <= head.op;
    if (pop) begin
      fwd_addr <= b_addr;
      fwd_data <= wr_data;
    end
    if (b_adv) o_data <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      fwd_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (pop) b_valid <= 1'b1;
      else if (b_adv) b_valid <= 1'b0;
      if (pop) fwd_valid <= wr_en;
      if (b_adv) o_valid <= 1'b1;
      else if (result.ready) o_valid <= 1'b0;
    end
  end

  assign result.valid = o_valid;
  assign result.data = o_data;

  a_pop_fills_stage: assert property (@(posedge clk) disable iff (rst)
    pop |=> b_valid)
    else $error("popped transaction did not reach the back stage");

  a_adv_fills_output: assert property (@(posedge clk) disable iff (rst)
    b_adv |=> o_valid)
    else $error("advanced transaction did not reach the output register");

  a_stall_holds_op: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_adv) |=> (b_valid && $stable(b_op)))
    else $error("stalled back stage lost its transaction");

  a_no_pop_into_full: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_adv) |-> !pop)
    else $error("pop while the back stage is stalled");

endmodule

### rtl/candle_flicker_node_update.sv
// A transaction is held in a queue slot, then in the back stage, then in the output register.
// Throughput: one transaction per cycle while results are taken, set by the separate read and
// write ports of the node state memory, with a forward path for back-to-back updates of one node.
// Reset clears the queue and pipeline control and returns the registers to their
// defaults; the node state memory is not cleared and each node must be loaded first.
module candle_flicker_node_update #(
  parameter int NODE_COUNT = cfn_pkg::NODE_COUNT_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  cfn_stream_if.sink   item,
  cfn_stream_if.source result,
  cfn_stream_if.sink   cfg
);
  import cfn_pkg::*;

  cfn_regs_t regs;
  cfn_head_t head;
  logic      pop;
  cfn_cfg_t  cfg_word;

  assign cfg.ready = 1'b1;
  assign cfg_word = cfg.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.wind_variability <= WIND_VARIABILITY_RESET;
      regs.flame_agility <= FLAME_AGILITY_RESET;
      regs.wind_calmness <= WIND_CALMNESS_RESET;
      regs.wind_baseline <= WIND_BASELINE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_word.index)
        REG_WIND_VARIABILITY: regs.wind_variability <= cfg_word.value;
        REG_FLAME_AGILITY:    regs.flame_agility <= cfg_word.value;
        REG_WIND_CALMNESS:    regs.wind_calmness <= cfg_word.value[CALM_W-1:0];
        REG_WIND_BASELINE:    regs.wind_baseline <= cfg_word.value;
        default:              regs <= regs;
      endcase
    end
  end

  cfn_front #(
    .NODE_COUNT (NODE_COUNT)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .pop  (pop),
    .head (head)
  );

  cfn_back #(
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .regs   (regs),
    .result (result)
  );

endmodule
